### sv/rsd_pkg.sv
// rsd_pkg: widths, defaults and command codes for the ring shorter-direction block.
// Used by rsd_root and ring_shorter_direction; depends on nothing.
package rsd_pkg;

    // parameter defaults
    localparam int RING_COUNT_DEF  = 8;
    localparam int RING_POINTS_DEF = 256;

    // item field widths
    localparam int RING_W  = 3;
    localparam int IDX_W   = 8;
    localparam int COORD_W = 32;
    localparam int LEN_W   = IDX_W + 1;
    localparam int DIST_W  = 36;

    // arithmetic widths
    localparam int AXIS_W  = 24;                 // saturated axis difference
    localparam int SQR_W   = 2 * AXIS_W;         // one squared axis difference
    localparam int SQ_W    = SQR_W + 1;          // dx^2 + dy^2
    localparam int FRAC_W  = 8;                  // fraction bits of a segment length
    localparam int ROOT_W  = 33;                 // floor(sqrt(sq * 2^16))
    localparam int SUM_W   = ROOT_W + IDX_W;     // up to 256 segments
    localparam int CEIL_W  = SUM_W + 1 - FRAC_W; // rounded-up integer distance

    // root unit: two radicand digit pairs per cycle
    localparam int ROOT_PAIRS = 34;
    localparam int ROOT_ITER  = ROOT_PAIRS / 2;
    localparam int ROOT_RAD_W = 2 * ROOT_PAIRS;
    localparam int ROOT_REM_W = ROOT_W + 4;
    localparam int ROOT_CNT_W = $clog2(ROOT_ITER + 1);

    // command codes
    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

endpackage

### sv/rsd_root.sv
// rsd_root: iterative integer square root, floor(sqrt(radicand * 2^16)).
// Two digit pairs per cycle; depends on rsd_pkg.
module rsd_root (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [rsd_pkg::SQ_W-1:0]       i_radicand,
    output logic                           o_done,
    output logic [rsd_pkg::ROOT_W-1:0]     o_root
);

    typedef struct packed {
        logic [rsd_pkg::ROOT_REM_W-1:0] rem;
        logic [rsd_pkg::ROOT_W-1:0]     root;
    } t_rstep;

    logic [rsd_pkg::ROOT_RAD_W-1:0] r_rad;
    logic [rsd_pkg::ROOT_REM_W-1:0] r_rem;
    logic [rsd_pkg::ROOT_W-1:0]     r_root;
    logic [rsd_pkg::ROOT_CNT_W-1:0] r_cnt;
    logic                           r_busy;
    logic                           r_done;
    t_rstep                         s1;
    t_rstep                         s2;

    // one restoring digit step
    function automatic t_rstep root_step(logic [rsd_pkg::ROOT_REM_W-1:0] rem,
                                         logic [rsd_pkg::ROOT_W-1:0] root,
                                         logic [1:0] pair);
        logic [rsd_pkg::ROOT_REM_W-1:0] rem_sh;
        logic [rsd_pkg::ROOT_REM_W-1:0] trial;
        t_rstep                         res;
        rem_sh = {rem[rsd_pkg::ROOT_REM_W-3:0], pair};
        trial  = rsd_pkg::ROOT_REM_W'({root, 2'b01});
        if (rem_sh >= trial) begin
            res.rem  = rem_sh - trial;
            res.root = {root[rsd_pkg::ROOT_W-2:0], 1'b1};
        end else begin
            res.rem  = rem_sh;
            res.root = {root[rsd_pkg::ROOT_W-2:0], 1'b0};
        end
        return res;
    endfunction

    always_comb begin
        s1 = root_step(r_rem, r_root, r_rad[rsd_pkg::ROOT_RAD_W-1 -: 2]);
        s2 = root_step(s1.rem, s1.root, r_rad[rsd_pkg::ROOT_RAD_W-3 -: 2]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            if (i_start) begin
                // radicand shifted by 2*FRAC_W, zero pad on top
                r_rad  <= rsd_pkg::ROOT_RAD_W'({i_radicand, {(2 * rsd_pkg::FRAC_W){1'b0}}});
                r_rem  <= '0;
                r_root <= '0;
                r_cnt  <= rsd_pkg::ROOT_CNT_W'(rsd_pkg::ROOT_ITER);
                r_busy <= 1'b1;
                r_done <= 1'b0;
            end else if (r_busy) begin
                r_rem  <= s2.rem;
                r_root <= s2.root;
                r_rad  <= {r_rad[rsd_pkg::ROOT_RAD_W-5:0], 4'b0000};
                r_cnt  <= r_cnt - rsd_pkg::ROOT_CNT_W'(1);
                r_done <= (r_cnt == rsd_pkg::ROOT_CNT_W'(1));
                if (r_cnt == rsd_pkg::ROOT_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end else begin
                r_done <= 1'b0;
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

### sv/ring_shorter_direction.sv
// ring_shorter_direction: point store for closed rings and shorter-way query sequencer.
// Depends on rsd_pkg and rsd_root.
//
//  channel | dir | handshake                 | payload
//  --------+-----+---------------------------+------------------------------------------
//  in      | in  | i_in_valid / o_in_stall   | func, ring, point_index, target_index,
//          |     |                           | coord_x, coord_y, last_point
//  out     | out | o_out_valid / i_out_stall | signed_distance, go_increasing,
//          |     |                           | next_index, bad_query
//
// A point write is a one-cycle transfer and gives no result. A query walks the ring
// both ways; the two walks together cover L segments for a ring of length L, each
// segment going through diff, two squarings, add and root start, root, accumulate,
// on one shared squarer and square-root unit; the query holds the input stalled.
// A rejected query goes straight to output; current == target passes the compare first.
// Synchronous active-low reset clears the sequencer, output valid and the ring
// length table; the point memories come up undefined and need no clearing.
// The input is stalled while a query is in flight; a finished result sits in the
// output register so the next transfer can be taken while it waits.
module ring_shorter_direction #(
    parameter int RING_COUNT  = rsd_pkg::RING_COUNT_DEF,
    parameter int RING_POINTS = rsd_pkg::RING_POINTS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // input channel
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic                               i_func,
    input  logic [rsd_pkg::RING_W-1:0]         i_ring,
    input  logic [rsd_pkg::IDX_W-1:0]          i_point_index,
    input  logic [rsd_pkg::IDX_W-1:0]          i_target_index,
    input  logic signed [rsd_pkg::COORD_W-1:0] i_coord_x,
    input  logic signed [rsd_pkg::COORD_W-1:0] i_coord_y,
    input  logic                               i_last_point,
    // result channel
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic signed [rsd_pkg::DIST_W-1:0]  o_signed_distance,
    output logic                               o_go_increasing,
    output logic [rsd_pkg::IDX_W-1:0]          o_next_index,
    output logic                               o_bad_query
);

    localparam int DEPTH = RING_COUNT * RING_POINTS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int RW    = (RING_COUNT > 1) ? $clog2(RING_COUNT) : 1;

    localparam int IDX_W  = rsd_pkg::IDX_W;
    localparam int LEN_W  = rsd_pkg::LEN_W;
    localparam int CRD_W  = rsd_pkg::COORD_W;
    localparam int AXIS_W = rsd_pkg::AXIS_W;
    localparam int SQR_W  = rsd_pkg::SQR_W;
    localparam int SQ_W   = rsd_pkg::SQ_W;
    localparam int SUM_W  = rsd_pkg::SUM_W;
    localparam int CEIL_W = rsd_pkg::CEIL_W;
    localparam int DIST_W = rsd_pkg::DIST_W;
    localparam int FRAC_W = rsd_pkg::FRAC_W;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_FIRST,   // read the walk's start point
        S_RD_NEXT,    // latch start point, read its neighbor
        S_DIFF,       // saturated axis differences
        S_MUL_X,
        S_MUL_Y,
        S_SUM,        // dx^2 + dy^2, kick the root unit
        S_ROOT,       // wait for root, accumulate, fetch next point
        S_CMP,        // pick direction
        S_OUT         // round up, load output register
    } t_state;

    // point memories
    logic [CRD_W-1:0]  r_mem_x [DEPTH];
    logic [CRD_W-1:0]  r_mem_y [DEPTH];
    logic [CRD_W-1:0]  r_rd_x;
    logic [CRD_W-1:0]  r_rd_y;

    logic [LEN_W-1:0]  r_len_tab [RING_COUNT];

    t_state            r_state;
    logic [AW-1:0]     r_base;
    logic [LEN_W-1:0]  r_len;
    logic [IDX_W-1:0]  r_cur;
    logic [IDX_W-1:0]  r_tgt;
    logic [IDX_W-1:0]  r_pos;
    logic              r_dec;
    logic [CRD_W-1:0]  r_prev_x;
    logic [CRD_W-1:0]  r_prev_y;
    logic [AXIS_W-1:0] r_dx;
    logic [AXIS_W-1:0] r_dy;
    logic [SQR_W-1:0]  r_sq;
    logic [SQR_W-1:0]  r_prod;
    logic [SUM_W-1:0]  r_sum_inc;
    logic [SUM_W-1:0]  r_sum_dec;
    logic [SUM_W-1:0]  r_pick;
    logic              r_go;
    logic [IDX_W-1:0]  r_next;
    logic              r_bad;

    logic              r_out_valid;
    logic [DIST_W-1:0] r_out_dist;
    logic              r_out_go;
    logic [IDX_W-1:0]  r_out_next;
    logic              r_out_bad;

    logic                      in_take;
    logic                      ring_ok;
    logic                      idx_ok;
    logic [LEN_W-1:0]          tab_len;
    logic                      q_bad;
    logic                      mem_we;
    logic [AW-1:0]             wr_addr;
    logic [AW-1:0]             ring_base;
    logic [IDX_W-1:0]          pos_step;
    logic                      rd_en;
    logic [IDX_W-1:0]          rd_idx;
    logic [AW-1:0]             rd_addr;
    logic [AXIS_W-1:0]         dx_sat;
    logic [AXIS_W-1:0]         dy_sat;
    logic [AXIS_W-1:0]         mul_op;
    logic [SQR_W-1:0]          mul_out;
    logic                      root_start;
    logic [SQ_W-1:0]           radicand;
    logic                      root_done;
    logic [rsd_pkg::ROOT_W-1:0] root_val;
    logic [SUM_W-1:0]          acc_sum;
    logic                      walk_end;
    logic [SUM_W:0]            ceil_sum;
    logic [CEIL_W-1:0]         ceil_mag;
    logic [DIST_W-1:0]         dist_val;
    logic                      out_load;

    // one step up / down the ring with wrap
    function automatic logic [IDX_W-1:0] step_up(logic [IDX_W-1:0] p, logic [LEN_W-1:0] len);
        return ((LEN_W'(p) + LEN_W'(1)) >= len) ? '0 : p + IDX_W'(1);
    endfunction

    function automatic logic [IDX_W-1:0] step_dn(logic [IDX_W-1:0] p, logic [LEN_W-1:0] len);
        return (p == '0) ? IDX_W'(len - LEN_W'(1)) : p - IDX_W'(1);
    endfunction

    // |a - b| saturated to the axis width
    function automatic logic [AXIS_W-1:0] axis_mag(logic [CRD_W-1:0] a, logic [CRD_W-1:0] b);
        logic [CRD_W:0] d;
        logic [CRD_W:0] m;
        d = {a[CRD_W-1], a} - {b[CRD_W-1], b};
        m = d[CRD_W] ? ((CRD_W + 1)'(0) - d) : d;
        return (|m[CRD_W:AXIS_W]) ? '1 : m[AXIS_W-1:0];
    endfunction

    assign in_take = i_in_valid && (r_state == S_IDLE);
    assign ring_ok = 32'(i_ring) < 32'(RING_COUNT);
    assign idx_ok  = 32'(i_point_index) < 32'(RING_POINTS);
    assign tab_len = ring_ok ? r_len_tab[RW'(i_ring)] : '0;
    assign q_bad   = (tab_len == '0) || (32'(tab_len) > 32'(RING_POINTS)) ||
                     (LEN_W'(i_point_index) >= tab_len) ||
                     (LEN_W'(i_target_index) >= tab_len);

    assign ring_base = AW'(i_ring) * AW'(RING_POINTS);
    assign wr_addr   = ring_base + AW'(i_point_index);
    assign mem_we    = in_take && (i_func == rsd_pkg::FUNC_WRITE) && ring_ok && idx_ok;

    assign pos_step = r_dec ? step_dn(r_pos, r_len) : step_up(r_pos, r_len);
    assign walk_end = (r_pos == r_tgt);

    always_comb begin
        rd_en  = 1'b0;
        rd_idx = pos_step;
        case (r_state)
            S_RD_FIRST: begin
                rd_en  = 1'b1;
                rd_idx = r_pos;
            end
            S_RD_NEXT: begin
                rd_en = 1'b1;
            end
            S_ROOT: begin
                rd_en = root_done && !walk_end;
            end
            default: begin
                rd_en = 1'b0;
            end
        endcase
    end

    assign rd_addr = r_base + AW'(rd_idx);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem_x[wr_addr] <= i_coord_x;
            r_mem_y[wr_addr] <= i_coord_y;
        end
        if (rd_en) begin
            r_rd_x <= r_mem_x[rd_addr];
            r_rd_y <= r_mem_y[rd_addr];
        end
    end

    // segment arithmetic: one squarer shared by both axes
    assign dx_sat     = axis_mag(r_prev_x, r_rd_x);
    assign dy_sat     = axis_mag(r_prev_y, r_rd_y);
    assign mul_op     = (r_state == S_MUL_X) ? r_dx : r_dy;
    assign mul_out    = SQR_W'(mul_op) * SQR_W'(mul_op);
    assign root_start = (r_state == S_SUM);
    assign radicand   = SQ_W'(r_sq) + SQ_W'(r_prod);

    rsd_root u_root (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (root_start),
        .i_radicand (radicand),
        .o_done     (root_done),
        .o_root     (root_val)
    );

    assign acc_sum = (r_dec ? r_sum_dec : r_sum_inc) + SUM_W'(root_val);

    // ceiling of the Q8 sum, negated for the decreasing way
    assign ceil_sum = (SUM_W + 1)'(r_pick) + (SUM_W + 1)'((1 << FRAC_W) - 1);
    assign ceil_mag = ceil_sum[SUM_W:FRAC_W];
    assign dist_val = r_go ? DIST_W'(ceil_mag) : (DIST_W'(0) - DIST_W'(ceil_mag));

    // output register takes a new result when empty or being drained
    assign out_load = (r_state == S_OUT) && (!r_out_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            for (int k = 0; k < RING_COUNT; k++) begin
                r_len_tab[k] <= '0;
            end
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        if (i_func == rsd_pkg::FUNC_WRITE) begin
                            if (ring_ok && idx_ok && i_last_point) begin
                                r_len_tab[RW'(i_ring)] <= LEN_W'(i_point_index) + LEN_W'(1);
                            end
                        end else begin
                            r_len     <= tab_len;
                            r_cur     <= i_point_index;
                            r_tgt     <= i_target_index;
                            r_pos     <= i_point_index;
                            r_base    <= ring_base;
                            r_dec     <= 1'b0;
                            r_sum_inc <= '0;
                            r_sum_dec <= '0;
                            r_bad     <= q_bad;
                            if (q_bad) begin
                                r_state <= S_OUT;
                            end else if (i_point_index == i_target_index) begin
                                r_state <= S_CMP;
                            end else begin
                                r_state <= S_RD_FIRST;
                            end
                        end
                    end
                end
                S_RD_FIRST: begin
                    r_state <= S_RD_NEXT;
                end
                S_RD_NEXT: begin
                    r_prev_x <= r_rd_x;
                    r_prev_y <= r_rd_y;
                    r_pos    <= pos_step;
                    r_state  <= S_DIFF;
                end
                S_DIFF: begin
                    r_dx     <= dx_sat;
                    r_dy     <= dy_sat;
                    r_prev_x <= r_rd_x;
                    r_prev_y <= r_rd_y;
                    r_state  <= S_MUL_X;
                end
                S_MUL_X: begin
                    r_sq    <= mul_out;
                    r_state <= S_MUL_Y;
                end
                S_MUL_Y: begin
                    r_prod  <= mul_out;
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    r_state <= S_ROOT;
                end
                S_ROOT: begin
                    if (root_done) begin
                        if (r_dec) begin
                            r_sum_dec <= acc_sum;
                        end else begin
                            r_sum_inc <= acc_sum;
                        end
                        if (!walk_end) begin
                            r_pos   <= pos_step;
                            r_state <= S_DIFF;
                        end else if (!r_dec) begin
                            // increasing walk done, start the decreasing one
                            r_dec   <= 1'b1;
                            r_pos   <= r_cur;
                            r_state <= S_RD_FIRST;
                        end else begin
                            r_state <= S_CMP;
                        end
                    end
                end
                S_CMP: begin
                    // tie goes decreasing
                    r_go    <= (r_sum_inc < r_sum_dec);
                    r_pick  <= (r_sum_inc < r_sum_dec) ? r_sum_inc : r_sum_dec;
                    r_next  <= (r_sum_inc < r_sum_dec) ? step_up(r_cur, r_len)
                                                       : step_dn(r_cur, r_len);
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (out_load) begin
                        r_out_bad   <= r_bad;
                        if (r_bad) begin
                            r_out_dist <= '0;
                            r_out_go   <= 1'b0;
                            r_out_next <= '0;
                        end else begin
                            r_out_dist <= dist_val;
                            r_out_go   <= r_go;
                            r_out_next <= r_next;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall        = (r_state != S_IDLE);
    assign o_out_valid       = r_out_valid;
    assign o_signed_distance = $signed(r_out_dist);
    assign o_go_increasing   = r_out_go;
    assign o_next_index      = r_out_next;
    assign o_bad_query       = r_out_bad;

endmodule
